### rtl/core/jjy_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and digit helpers for the JJY time-code encoder.
// No dependencies; every other file of the block uses this package.
package jjy_pkg;

	localparam int FRAME_W     = 60;
	localparam int PULSE_W     = 10;
	localparam int SEC_W       = 6;
	localparam int LAST_SECOND = 59;

	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [PULSE_W-1:0] pulse_t;
	typedef logic [SEC_W-1:0]   sec_t;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam pulse_t PULSE_NONE   = 10'd0;
	localparam pulse_t PULSE_MARKER = 10'd200;
	localparam pulse_t PULSE_ONE    = 10'd500;
	localparam pulse_t PULSE_ZERO   = 10'd800;

	// Quotient and remainder of a value below 1024 split by ten.
	typedef struct packed {
		logic [6:0] quo;
		logic [3:0] rem;
	} dec_split_t;

	// Reciprocal multiply: (v * 205) >> 11 is exact for every v below 1029.
	function automatic dec_split_t split10(input logic [9:0] v);
		logic [17:0] prod;
		logic [9:0]  back;
		dec_split_t  res;
		prod     = 18'(v) * 18'd205;
		res.quo  = prod[17:11];
		back     = 10'(res.quo) * 10'd10;
		res.rem  = 4'(v - back);
		return res;
	endfunction

	// Load fields handed from the input stage to the frame builder.
	typedef struct packed {
		logic [5:0] minute;
		logic [4:0] hour;
		logic [8:0] day_of_year;
		logic [6:0] year_two_digit;
		logic [2:0] weekday;
	} load_fields_t;

endpackage
`default_nettype wire

### rtl/core/jjy_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the JJY encoder: input items and results.
// Depends on jjy_pkg for the result width.
interface jjy_item_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [5:0] minute;
	logic [4:0] hour;
	logic [8:0] day_of_year;
	logic [6:0] year_two_digit;
	logic [2:0] weekday;
	logic [5:0] second;

	modport source (output valid, req_type, minute, hour, day_of_year,
		year_two_digit, weekday, second, input ready);
	modport sink (input valid, req_type, minute, hour, day_of_year,
		year_two_digit, weekday, second, output ready);
endinterface

interface jjy_result_if;
	logic                 valid;
	logic                 ready;
	jjy_pkg::pulse_t      pulse_ms;

	modport source (output valid, pulse_ms, input ready);
	modport sink (input valid, pulse_ms, output ready);
endinterface
`default_nettype wire

### rtl/core/jjy_frame_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// Combinational assembly of one 60-bit JJY frame from the load fields.
// Depends on jjy_pkg (split10, frame_t, load_fields_t).
module jjy_frame_builder (
	input  jjy_pkg::load_fields_t fields,
	output jjy_pkg::frame_t       frame
);
	import jjy_pkg::*;

	dec_split_t min_d, hour_d, day_lo, day_hi, year_d;
	logic [9:0] day_plus1;
	logic [6:0] year_mod;

	always_comb begin
		day_plus1 = 10'(fields.day_of_year) + 10'd1;
		year_mod  = (fields.year_two_digit >= 7'd100) ?
			fields.year_two_digit - 7'd100 : fields.year_two_digit;
		min_d     = split10(10'(fields.minute));
		hour_d    = split10(10'(fields.hour));
		day_lo    = split10(day_plus1);
		day_hi    = split10(10'(day_lo.quo));
		year_d    = split10(10'(year_mod));
	end

	always_comb begin
		frame          = '0;
		// minute, padded BCD
		frame[54:51]   = min_d.rem;
		frame[58:56]   = min_d.quo[2:0];
		// hour, padded BCD
		frame[44:41]   = hour_d.rem;
		frame[47:46]   = hour_d.quo[1:0];
		// day of year plus one, padded BCD in three digits
		frame[29:26]   = day_lo.rem;
		frame[34:31]   = day_hi.rem;
		frame[38:36]   = day_hi.quo[2:0];
		// year, plain BCD
		frame[14:11]   = year_d.rem;
		frame[18:15]   = year_d.quo[3:0];
		// weekday
		frame[9:7]     = fields.weekday;
		// even parity over hour and minute slots
		frame[23]      = ^frame[47:41];
		frame[22]      = ^frame[58:51];
	end

endmodule
`default_nettype wire

### rtl/core/jjy_pulse_select.sv
`timescale 1ns / 1ps
`default_nettype none
// Maps a second of the stored frame to its carrier high time.
// Depends on jjy_pkg (pulse constants, split10).
module jjy_pulse_select (
	input  jjy_pkg::frame_t frame,
	input  logic            frame_valid,
	input  jjy_pkg::sec_t   second,
	output jjy_pkg::pulse_t pulse_ms
);
	import jjy_pkg::*;

	dec_split_t sec_d;
	logic [5:0] bit_pos;
	logic       is_marker;

	always_comb begin
		sec_d     = split10(10'(second));
		bit_pos   = 6'(LAST_SECOND) - second;
		is_marker = (second == '0) || (sec_d.rem == 4'd9) ||
			(second > 6'(LAST_SECOND));
		if (!frame_valid) begin
			pulse_ms = PULSE_NONE;
		end else if (is_marker) begin
			pulse_ms = PULSE_MARKER;
		end else if (frame[bit_pos]) begin
			pulse_ms = PULSE_ONE;
		end else begin
			pulse_ms = PULSE_ZERO;
		end
	end

endmodule
`default_nettype wire

### rtl/core/jjy_time_code_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// JJY time-code encoder. Send a load transfer (req_type 0) with minute, hour,
// zero-based day of year, two-digit year and weekday to build a new 60-bit frame;
// it returns nothing. Send a query transfer (req_type 1) with a second to get one
// result: pulse_ms is 0 before any load, 200 for a marker (second 0, seconds ending
// in 9, seconds above 59), otherwise 500 for a one bit and 800 for a zero bit.
// The block takes one transfer per clock while the input is not held: each item
// passes through the input register, the frame or pulse logic runs between that
// register and the frame or result register, and a result is offered from the
// result register. A finished result may wait in the result register while the
// next items are accepted; only a query that finds the result register full and
// not draining holds the input.
// Depends on jjy_pkg, jjy_channels, jjy_frame_builder and jjy_pulse_select.
module jjy_time_code_encoder (
	input  logic                clk,
	input  logic                arst_n,
	jjy_item_if.sink            item,
	jjy_result_if.source        result
);
	import jjy_pkg::*;

	// input stage
	logic         valid_s1;
	logic         req_s1;
	load_fields_t fields_s1;
	sec_t         second_s1;
	logic         advance_s1;

	// frame store
	frame_t frame_q;
	logic   frame_valid_q;
	frame_t frame_next;

	// result register
	logic   out_valid_q;
	pulse_t out_pulse_q;
	pulse_t pulse_next;

	// A query needs a free result slot; loads always leave the stage.
	assign advance_s1 = !valid_s1 || (req_s1 == REQ_LOAD) || !out_valid_q ||
		result.ready;
	assign item.ready = advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= item.valid;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (advance_s1 && item.valid) begin
			req_s1                    <= item.req_type;
			fields_s1.minute          <= item.minute;
			fields_s1.hour            <= item.hour;
			fields_s1.day_of_year     <= item.day_of_year;
			fields_s1.year_two_digit  <= item.year_two_digit;
			fields_s1.weekday         <= item.weekday;
			second_s1                 <= item.second;
		end
	end

	jjy_frame_builder u_builder (
		.fields (fields_s1),
		.frame  (frame_next)
	);

	jjy_pulse_select u_select (
		.frame       (frame_q),
		.frame_valid (frame_valid_q),
		.second      (second_s1),
		.pulse_ms    (pulse_next)
	);

	// Commit a load into the frame store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (valid_s1 && req_s1 == REQ_LOAD) begin
			frame_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && req_s1 == REQ_LOAD) begin
			frame_q <= frame_next;
		end
	end

	// Result register: fill on a leaving query, drop on an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && req_s1 == REQ_QUERY && advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && req_s1 == REQ_QUERY && advance_s1) begin
			out_pulse_q <= pulse_next;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.pulse_ms = out_pulse_q;

endmodule
`default_nettype wire
